// ===== sv/vrt_pkg.sv =====
// shared constants, codes and controller/datapath link types for the voxel ray walk
package vrt_pkg;

    localparam int CELL_BITS = 16;
    localparam int FRAC_BITS = 16;
    localparam int DIR_FRAC  = 14;

    // dividend width: 2^(DIR_FRAC+FRAC_BITS) must fit
    localparam int DIV_W  = DIR_FRAC + FRAC_BITS + 1;
    localparam int DIV_CW = $clog2(DIV_W + 1);
    localparam int MAG_W  = 16;
    localparam int QX_W   = (DIV_W > 33) ? DIV_W : 33;
    localparam int NJOBS  = 6;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_HIT   = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    localparam logic [1:0] STEP_NONE  = 2'd0;
    localparam logic [1:0] STEP_PLUS  = 2'd1;
    localparam logic [1:0] STEP_MINUS = 2'd3;

    localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

    typedef struct packed {
        logic       load;
        logic       div_go;
        logic [2:0] div_job;
        logic       setup_end;
        logic       answer;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
    } t_dp_sts;

endpackage

// ===== sv/vrt_if.sv =====
// handshake channels: ray request items in, query/hit/miss items out
interface vrt_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] max_distance;
    logic               cell_solid;

    modport source (output valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y,
                    dir_z, max_distance, cell_solid, input ready);
    modport sink (input valid, req_type, origin_x, origin_y, origin_z, dir_x, dir_y,
                  dir_z, max_distance, cell_solid, output ready);
endinterface

interface vrt_out_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  kind;
    logic signed [15:0] cell_x;
    logic signed [15:0] cell_y;
    logic signed [15:0] cell_z;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic signed [15:0] prev_z;

    modport source (output valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
                    input ready);
    modport sink (input valid, kind, cell_x, cell_y, cell_z, prev_x, prev_y, prev_z,
                  output ready);
endinterface

// ===== sv/voxel_ray_traversal.sv =====
// top level of the 3d voxel ray walk: controller plus datapath
//
//  channel | dir | handshake     | carries
//  i_in    | in  | valid / ready | start (origin, direction, max distance) or solidity answer
//  o_out   | out | valid / ready | query, hit or miss with cell and previous cell
//
// a start item takes 6 divisions (one quotient bit a cycle in the
// shared divider) plus the setup sequencing
// an answer item goes through accept, step, result
// one item is in flight at a time; the input is held off until its result is taken
// reset is synchronous, active low, and leaves the walk idle
module voxel_ray_traversal (
    input  logic      i_clk,
    input  logic      i_rst_n,
    vrt_in_if.sink    i_in,
    vrt_out_if.source o_out
);
    import vrt_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    vrt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in.valid),
        .i_in_req_type (i_in.req_type),
        .i_out_ready   (o_out.ready),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd),
        .o_in_ready    (i_in.ready),
        .o_out_valid   (o_out.valid)
    );

    vrt_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

// ===== sv/vrt_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
module vrt_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vrt_pkg::DIV_W-1:0]   i_dividend,
    input  logic [vrt_pkg::MAG_W-1:0]   i_divisor,
    output logic                        o_done,
    output logic [vrt_pkg::DIV_W-1:0]   o_quot
);
    import vrt_pkg::*;

    logic [MAG_W:0]    r_rem, n_rem;
    logic [DIV_W-1:0]  r_quot, n_quot;
    logic [MAG_W-1:0]  r_div;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [MAG_W:0]    w_shift;

    always_comb begin
        w_shift = {r_rem[MAG_W-1:0], r_quot[DIV_W-1]};
        if (w_shift >= {1'b0, r_div}) begin
            n_rem  = w_shift - {1'b0, r_div};
            n_quot = {r_quot[DIV_W-2:0], 1'b1};
        end else begin
            n_rem  = w_shift;
            n_quot = {r_quot[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= n_quot;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

// ===== sv/vrt_dp.sv =====
// datapath: ray state, setup divisions, axis step and result register
module vrt_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vrt_pkg::t_dp_cmd  i_cmd,
    output vrt_pkg::t_dp_sts  o_sts,
    vrt_in_if.sink            i_in,
    vrt_out_if.source         o_out
);
    import vrt_pkg::*;

    logic [CELL_BITS-1:0] r_cur [3];
    logic [CELL_BITS-1:0] r_prev [3];
    logic [1:0]           r_step [3];
    logic [31:0]          r_nb [3];
    logic [31:0]          r_span [3];
    logic [MAG_W-1:0]     r_mag [3];
    logic [FRAC_BITS:0]   r_dist [3];
    logic signed [31:0]   r_limit;
    logic                 r_active;
    logic                 r_solid;

    logic [1:0]  r_kind;
    logic [15:0] r_oc [3];
    logic [15:0] r_op [3];

    logic signed [31:0] w_org [3];
    logic signed [15:0] w_dir [3];
    logic [DIV_W-1:0]   w_dvd;
    logic [1:0]         w_jax;
    logic               w_done;
    logic [DIV_W-1:0]   w_quot;
    logic [QX_W-1:0]    w_qx;
    logic [31:0]        w_qsat;
    logic [1:0]         w_ax;
    logic [32:0]        w_sum;
    logic [31:0]        w_t;
    logic               w_in_range;

    assign w_org[0] = i_in.origin_x;
    assign w_org[1] = i_in.origin_y;
    assign w_org[2] = i_in.origin_z;
    assign w_dir[0] = i_in.dir_x;
    assign w_dir[1] = i_in.dir_y;
    assign w_dir[2] = i_in.dir_z;

    // job bit 0 picks boundary over span, upper bits pick the axis
    assign w_jax = i_cmd.div_job[2:1];
    always_comb begin
        if (i_cmd.div_job[0])
            w_dvd = DIV_W'({r_dist[w_jax], DIR_FRAC'(0)});
        else
            w_dvd = DIV_W'(1) << (DIR_FRAC + FRAC_BITS);
    end

    vrt_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_go),
        .i_dividend (w_dvd),
        .i_divisor  (r_mag[w_jax]),
        .o_done     (w_done),
        .o_quot     (w_quot)
    );

    assign o_sts.div_done = w_done;
    assign w_qx   = QX_W'(w_quot);
    assign w_qsat = (|w_qx[QX_W-1:32]) ? SAT32 : w_qx[31:0];

    // axis with the nearest boundary, ties go to the higher-numbered axis
    always_comb begin
        if (r_nb[0] < r_nb[1])
            w_ax = (r_nb[0] < r_nb[2]) ? 2'd0 : 2'd2;
        else
            w_ax = (r_nb[1] < r_nb[2]) ? 2'd1 : 2'd2;
        w_t        = r_nb[w_ax];
        w_sum      = {1'b0, r_nb[w_ax]} + {1'b0, r_span[w_ax]};
        w_in_range = !r_limit[31] && (w_t <= r_limit[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            if (i_cmd.setup_end)
                r_active <= !r_limit[31];
            else if (i_cmd.answer && r_active && (r_solid || !w_in_range))
                r_active <= 1'b0;
        end

        if (i_cmd.load) begin
            r_solid <= i_in.cell_solid;
            if (!i_in.req_type) begin
                r_limit <= i_in.max_distance;
                for (int a = 0; a < 3; a++) begin
                    r_cur[a]  <= CELL_BITS'(w_org[a] >>> FRAC_BITS);
                    r_prev[a] <= CELL_BITS'(w_org[a] >>> FRAC_BITS);
                    if (w_dir[a] == 16'sd0) begin
                        r_step[a] <= STEP_NONE;
                        r_mag[a]  <= '0;
                        r_dist[a] <= '0;
                    end else if (!w_dir[a][15]) begin
                        r_step[a] <= STEP_PLUS;
                        r_mag[a]  <= MAG_W'(w_dir[a]);
                        r_dist[a] <= ((FRAC_BITS+1)'(1) << FRAC_BITS)
                                     - {1'b0, w_org[a][FRAC_BITS-1:0]};
                    end else begin
                        r_step[a] <= STEP_MINUS;
                        r_mag[a]  <= MAG_W'(-{w_dir[a][15], w_dir[a]});
                        r_dist[a] <= {1'b0, w_org[a][FRAC_BITS-1:0]};
                    end
                end
            end
        end

        if (w_done) begin
            if (i_cmd.div_job[0])
                r_nb[w_jax] <= (r_step[w_jax] == STEP_NONE) ? SAT32 : w_qsat;
            else
                r_span[w_jax] <= (r_step[w_jax] == STEP_NONE) ? SAT32 : w_qsat;
        end

        if (i_cmd.setup_end) begin
            r_kind <= r_limit[31] ? KIND_MISS : KIND_QUERY;
            for (int a = 0; a < 3; a++) begin
                r_oc[a] <= r_limit[31] ? 16'd0 : 16'(r_cur[a]);
                r_op[a] <= 16'd0;
            end
        end

        if (i_cmd.answer) begin
            if (!r_active) begin
                r_kind <= KIND_MISS;
                for (int a = 0; a < 3; a++) begin
                    r_oc[a] <= 16'd0;
                    r_op[a] <= 16'd0;
                end
            end else if (r_solid) begin
                r_kind <= KIND_HIT;
                for (int a = 0; a < 3; a++) begin
                    r_oc[a] <= 16'(r_cur[a]);
                    r_op[a] <= 16'(r_prev[a]);
                end
            end else begin
                for (int a = 0; a < 3; a++)
                    r_prev[a] <= r_cur[a];
                r_nb[w_ax] <= w_sum[32] ? SAT32 : w_sum[31:0];
                for (int a = 0; a < 3; a++) begin
                    if (a == int'(w_ax)) begin
                        case (r_step[a])
                            STEP_PLUS:  r_cur[a] <= r_cur[a] + 1'b1;
                            STEP_MINUS: r_cur[a] <= r_cur[a] - 1'b1;
                            default:    r_cur[a] <= r_cur[a];
                        endcase
                    end
                end
                for (int a = 0; a < 3; a++)
                    r_op[a] <= 16'd0;
                if (w_in_range) begin
                    r_kind <= KIND_QUERY;
                    for (int a = 0; a < 3; a++) begin
                        if (a == int'(w_ax) && r_step[a] == STEP_PLUS)
                            r_oc[a] <= 16'(r_cur[a] + 1'b1);
                        else if (a == int'(w_ax) && r_step[a] == STEP_MINUS)
                            r_oc[a] <= 16'(r_cur[a] - 1'b1);
                        else
                            r_oc[a] <= 16'(r_cur[a]);
                    end
                end else begin
                    r_kind <= KIND_MISS;
                    for (int a = 0; a < 3; a++)
                        r_oc[a] <= 16'd0;
                end
            end
        end
    end

    assign o_out.kind   = r_kind;
    assign o_out.cell_x = r_oc[0];
    assign o_out.cell_y = r_oc[1];
    assign o_out.cell_z = r_oc[2];
    assign o_out.prev_x = r_op[0];
    assign o_out.prev_y = r_op[1];
    assign o_out.prev_z = r_op[2];
endmodule

// ===== sv/vrt_ctrl.sv =====
// controller: sequences setup divisions, answer step and result handoff
module vrt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_req_type,
    input  logic              i_out_ready,
    input  vrt_pkg::t_dp_sts  i_sts,
    output vrt_pkg::t_dp_cmd  o_cmd,
    output logic              o_in_ready,
    output logic              o_out_valid
);
    import vrt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV_GO, S_DIV_WAIT, S_SETUP_END, S_STEP, S_OUT
    } t_state;

    t_state     r_state;
    logic [2:0] r_job;
    logic       r_in_ready, r_out_valid;
    logic       w_in_acc;

    assign w_in_acc = i_in_valid && r_in_ready;

    always_comb begin
        o_cmd.load      = w_in_acc;
        o_cmd.div_go    = (r_state == S_DIV_GO);
        o_cmd.div_job   = r_job;
        o_cmd.setup_end = (r_state == S_SETUP_END);
        o_cmd.answer    = (r_state == S_STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= '0;
            r_in_ready  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in_ready <= 1'b0;
                        r_job      <= '0;
                        r_state    <= i_in_req_type ? S_STEP : S_DIV_GO;
                    end
                end
                S_DIV_GO: begin
                    r_state <= S_DIV_WAIT;
                end
                S_DIV_WAIT: begin
                    if (i_sts.div_done) begin
                        if (r_job == 3'(NJOBS - 1)) begin
                            r_state <= S_SETUP_END;
                        end else begin
                            r_job   <= r_job + 1'b1;
                            r_state <= S_DIV_GO;
                        end
                    end
                end
                S_SETUP_END, S_STEP: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_in_ready  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
endmodule

// ===== tb/vrt_tb_if.sv =====
`timescale 1ns / 1ps
// testbench-side interfaces: none, the channels reuse the design's handshake interfaces

// ===== tb/vrt_checker.sv =====
`timescale 1ns / 1ps
// checker: predicts the ray walk from accepted request items and compares output items
module vrt_checker (
    input  logic   i_clk,
    input  logic   i_rst_n,
    vrt_in_if      i_in,
    vrt_out_if     o_out,
    output int     o_fail_count,
    output int     o_pending
);
    import vrt_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] cx, cy, cz, px, py, pz;
    } t_walk_result;

    t_walk_result result_q[$];

    logic [15:0] walk_cell [3];
    logic [15:0] prev [3];
    logic [1:0]  stepc [3];
    logic [31:0] bound [3];
    logic [31:0] span [3];
    logic [31:0] t_now;
    logic signed [31:0] t_limit;
    logic        walking;

    function automatic logic [31:0] clamp32(logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? SAT32 : v[31:0];
    endfunction

    function automatic logic within_limit(logic [31:0] t, logic signed [31:0] lim);
        if (lim < 0) return 1'b0;
        return {32'd0, t} <= {32'd0, lim};
    endfunction

    task automatic init_axis(int a, logic [31:0] org, logic signed [15:0] d);
        logic [63:0] mag, gap_len;
        logic [15:0] frac;
        frac = org[15:0];
        walk_cell[a] = org[31:16];
        prev[a] = org[31:16];
        if (d == 0) begin
            stepc[a] = STEP_NONE;
            span[a] = SAT32;
            bound[a] = SAT32;
        end else begin
            if (d > 0) begin
                mag = 64'(d);
                stepc[a] = STEP_PLUS;
                gap_len = 64'h1_0000 - 64'(frac);
            end else begin
                mag = 64'(-32'(d));
                stepc[a] = STEP_MINUS;
                gap_len = 64'(frac);
            end
            span[a] = clamp32((64'd1 << 30) / mag);
            bound[a] = clamp32((gap_len << 14) / mag);
        end
    endtask

    task automatic predict_walk();
        t_walk_result r;
        int a;
        r = '0;
        if (!i_in.req_type) begin
            init_axis(0, i_in.origin_x, i_in.dir_x);
            init_axis(1, i_in.origin_y, i_in.dir_y);
            init_axis(2, i_in.origin_z, i_in.dir_z);
            t_limit = i_in.max_distance;
            t_now = '0;
            walking = within_limit(t_now, t_limit);
            r.kind = walking ? KIND_QUERY : KIND_MISS;
            if (walking) {r.cx, r.cy, r.cz} = {walk_cell[0], walk_cell[1], walk_cell[2]};
        end else if (!walking) begin
            r.kind = KIND_MISS;
        end else if (i_in.cell_solid) begin
            walking = 1'b0;
            r.kind = KIND_HIT;
            {r.cx, r.cy, r.cz} = {walk_cell[0], walk_cell[1], walk_cell[2]};
            {r.px, r.py, r.pz} = {prev[0], prev[1], prev[2]};
        end else begin
            for (int i = 0; i < 3; i++) prev[i] = walk_cell[i];
            if (bound[0] < bound[1]) a = (bound[0] < bound[2]) ? 0 : 2;
            else a = (bound[1] < bound[2]) ? 1 : 2;
            t_now = bound[a];
            bound[a] = clamp32(64'(bound[a]) + 64'(span[a]));
            if (stepc[a] == STEP_PLUS) walk_cell[a] = walk_cell[a] + 16'd1;
            else if (stepc[a] == STEP_MINUS) walk_cell[a] = walk_cell[a] - 16'd1;
            walking = within_limit(t_now, t_limit);
            r.kind = walking ? KIND_QUERY : KIND_MISS;
            if (walking) {r.cx, r.cy, r.cz} = {walk_cell[0], walk_cell[1], walk_cell[2]};
        end
        result_q.push_back(r);
    endtask

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %h actual %h", name, exp_v, act_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_walk_result e;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                walk_cell[i] = '0; prev[i] = '0; stepc[i] = '0; bound[i] = '0; span[i] = '0;
            end
            t_now = '0;
            t_limit = '0;
            walking = 1'b0;
            result_q.delete();
        end else begin
            if (o_out.valid && o_out.ready) begin
                if (result_q.size() == 0) begin
                    $error("unexpected output item kind %0d", o_out.kind);
                    o_fail_count++;
                end else begin
                    e = result_q.pop_front();
                    compare_field("kind", 16'(e.kind), 16'(o_out.kind));
                    compare_field("cell_x", e.cx, o_out.cell_x);
                    compare_field("cell_y", e.cy, o_out.cell_y);
                    compare_field("cell_z", e.cz, o_out.cell_z);
                    compare_field("prev_x", e.px, o_out.prev_x);
                    compare_field("prev_y", e.py, o_out.prev_y);
                    compare_field("prev_z", e.pz, o_out.prev_z);
                end
            end
            if (i_in.valid && i_in.ready) predict_walk();
        end
        o_pending = result_q.size();
    end

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end
endmodule

// ===== tb/tb_voxel_ray_traversal.sv =====
`timescale 1ns / 1ps
// testbench top: ray stimulus, output stalls and verdict
module tb_voxel_ray_traversal;
    import vrt_pkg::*;

    localparam int RAND_ITEMS = 1300;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    logic stim_done;

    vrt_in_if  in_ch ();
    vrt_out_if out_ch ();

    voxel_ray_traversal dut (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink),
                             .o_out(out_ch.source));

    vrt_checker chk (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
                     .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("FAIL voxel_ray_traversal");
        $finish;
    end

    // send one item, after a random gap when gaps is set
    task automatic send_item(logic rt, logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                             logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                             logic [31:0] md, logic solid, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= rt;
        in_ch.origin_x <= ox;
        in_ch.origin_y <= oy;
        in_ch.origin_z <= oz;
        in_ch.dir_x <= dx;
        in_ch.dir_y <= dy;
        in_ch.dir_z <= dz;
        in_ch.max_distance <= md;
        in_ch.cell_solid <= solid;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_answer(logic solid, bit gaps);
        send_item(1'b1, 32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 32'($urandom), solid, gaps);
    endtask

    function automatic logic [15:0] rand_dir();
        case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'h8000;
            2: return 16'h7FFF;
            3: return 16'($urandom_range(1, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int sent, steps;
        bit gaps;
        i_rst_n = 1'b0;
        stim_done = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.req_type = 1'b0;
        in_ch.origin_x = '0;
        in_ch.origin_y = '0;
        in_ch.origin_z = '0;
        in_ch.dir_x = '0;
        in_ch.dir_y = '0;
        in_ch.dir_z = '0;
        in_ch.max_distance = '0;
        in_ch.cell_solid = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle answers, extremes, negative limit, zero axes, wrap, abort
        send_answer(1'b0, 1'b0);
        send_answer(1'b1, 1'b0);
        send_item(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h8000, 16'h7FFF, 16'h0,
                  32'h7FFF_FFFF, 1'b0, 1'b0);
        repeat (4) send_answer(1'b0, 1'b0);
        send_answer(1'b1, 1'b0);
        send_item(1'b0, 32'h1234_5678, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0,
                  32'h8000_0000, 1'b0, 1'b0);
        send_item(1'b0, 32'h7FFF_8000, 32'hFFFF_FFFF, 32'h8000_0000, 16'h0001, 16'hFFFF,
                  16'h0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        repeat (3) send_answer(1'b0, 1'b0);
        send_item(1'b0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 32'h0, 1'b0, 1'b0);
        send_answer(1'b0, 1'b0);
        send_item(1'b0, 32'h0001_8000, 32'h0, 32'h0, 16'h4000, 16'h4000, 16'h4000,
                  32'h0003_0000, 1'b0, 1'b0);
        repeat (6) send_answer(1'b0, 1'b0);
        wait_drained();

        // random rays; some phases without gaps
        sent = 0;
        while (sent < RAND_ITEMS) begin
            gaps = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) == 0) begin
                send_answer(1'($urandom_range(0, 1)), gaps);
                sent++;
            end else begin
                send_item(1'b0, 32'($urandom), 32'($urandom), 32'($urandom), rand_dir(),
                          rand_dir(), rand_dir(), ($urandom_range(0, 7) == 0) ? 32'($urandom)
                          : 32'($urandom_range(0, 32'h0040_0000)), 1'b0, gaps);
                sent++;
                steps = $urandom_range(0, 25);
                for (int k = 0; k < steps && sent < RAND_ITEMS; k++) begin
                    send_answer($urandom_range(0, 15) == 0, gaps);
                    sent++;
                end
            end
            if ($urandom_range(0, 40) == 0) wait_drained();
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, with one long hold-off early on
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        repeat (30) @(posedge i_clk);
        out_ch.ready <= 1'b0;
        repeat (600) @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    initial begin
        int guard;
        wait (stim_done);
        guard = 0;
        while (pending != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (300) @(posedge i_clk);
        if (pending == 0 && fail_count == 0)
            $display("PASS voxel_ray_traversal");
        else
            $display("FAIL voxel_ray_traversal");
        $finish;
    end
endmodule
